// File: rtl/core/bfha_pkg.sv
// Shared types and constants for the best-fit hole allocator.
// No dependencies; used by the controller, datapath and top level.
package bfha_pkg;

    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int SIZE_W    = 33;
    localparam int PORT_AW   = 32;
    localparam logic [SIZE_W-1:0] MEM_RESET = 33'd1048576;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    // table reshaping needed after the decision step
    typedef enum logic [1:0] {
        ACT_DONE = 2'd0,
        ACT_SHDN = 2'd1,
        ACT_SHUP = 2'd2,
        ACT_RSVD = 2'd3
    } t_act;

    typedef struct packed {
        logic boot;
        logic load;
        logic scan_rd;
        logic scan_ev;
        logic decide;
        logic dn_rd;
        logic dn_wr;
        logic up_rd;
        logic up_wr;
        logic put;
        logic dec_count;
    } t_dp_ctl;

    typedef struct packed {
        logic scan_req;
        logic next_lt_cnt;
        logic idx_gt_pos;
        t_act act;
    } t_dp_sts;

endpackage

// File: rtl/core/bfha_datapath.sv
// Datapath: hole table memory, scan/compare logic, free-word total.
// Depends on bfha_pkg; sequenced by bfha_ctrl.
module bfha_datapath #(
    parameter int MAX_HOLES = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bfha_pkg::SIZE_W-1:0]   i_cfg_wdata,
    input  logic [bfha_pkg::CMD_W-1:0]    i_cmd,
    input  logic [bfha_pkg::PORT_AW-1:0]  i_region_start,
    input  logic [bfha_pkg::SIZE_W-1:0]   i_region_size,
    input  bfha_pkg::t_dp_ctl             i_ctl,
    output bfha_pkg::t_dp_sts             o_sts,
    output logic [bfha_pkg::PORT_AW-1:0]  o_base_address,
    output logic [bfha_pkg::PORT_AW-1:0]  o_last_address,
    output logic [bfha_pkg::STATUS_W-1:0] o_status,
    output logic [bfha_pkg::SIZE_W-1:0]   o_free_total
);
    localparam int IW   = $clog2(MAX_HOLES);
    localparam int CNTW = $clog2(MAX_HOLES + 1);
    localparam int CW   = ((ADDR_BITS > bfha_pkg::SIZE_W) ? ADDR_BITS : bfha_pkg::SIZE_W) + 1;
    localparam int SW   = bfha_pkg::SIZE_W;

    logic [CW-1:0] r_mem_first [MAX_HOLES];
    logic [CW-1:0] r_mem_last  [MAX_HOLES];
    logic [CW-1:0] r_rd_first, r_rd_last;

    logic [SW-1:0]   r_mem_size;
    logic [CNTW-1:0] r_count;
    logic [SW-1:0]   r_free;

    bfha_pkg::t_cmd    r_cmd;
    bfha_pkg::t_status r_status;
    logic [CW-1:0]   r_start, r_size, r_end;
    logic [CNTW-1:0] r_idx;
    logic            r_found;
    logic [CW-1:0]   r_best, r_pick_first;
    logic [IW-1:0]   r_pick;
    logic            r_ovl, r_left_vld, r_pos_found;
    logic [IW-1:0]   r_left_idx;
    logic [CW-1:0]   r_left_last, r_right_first, r_right_last;
    logic [CNTW-1:0] r_pos;
    logic [CW-1:0]   r_base, r_laddr;

    logic [CW-1:0]   mem_ext, cap, eff, hs;
    logic [CNTW-1:0] pos_sel, raddr_c;
    logic            join_l, join_r, free_ok, alloc_ok, tbl_full;
    logic            we_f, we_l;
    logic [IW-1:0]   waddr;
    logic [CW-1:0]   wd_f, wd_l;
    bfha_pkg::t_act  act;

    assign mem_ext  = CW'(r_mem_size);
    assign cap      = CW'(1) << ADDR_BITS;
    assign eff      = (mem_ext > cap) ? cap : mem_ext;
    assign hs       = r_rd_last - r_rd_first + CW'(1);
    assign pos_sel  = r_pos_found ? r_pos : r_count;
    assign join_l   = r_left_vld && ((r_left_last + CW'(1)) == r_start);
    assign join_r   = r_pos_found && ((r_end + CW'(1)) == r_right_first);
    assign free_ok  = (r_size != '0) && (r_end < eff) && !r_ovl;
    assign alloc_ok = (r_size != '0) && r_found;
    assign tbl_full = (r_count >= CNTW'(MAX_HOLES));

    always_comb begin
        act = bfha_pkg::ACT_DONE;
        case (r_cmd)
            bfha_pkg::CMD_ALLOC: begin
                if (alloc_ok && (r_best == r_size)) act = bfha_pkg::ACT_SHDN;
            end
            bfha_pkg::CMD_FREE: begin
                if (free_ok && join_l && join_r) act = bfha_pkg::ACT_SHDN;
                else if (free_ok && !join_l && !join_r && !tbl_full) act = bfha_pkg::ACT_SHUP;
            end
            default: act = bfha_pkg::ACT_DONE;
        endcase
    end

    assign o_sts.scan_req    = ((i_cmd == bfha_pkg::CMD_ALLOC) || (i_cmd == bfha_pkg::CMD_FREE))
                               && (r_count != '0);
    assign o_sts.next_lt_cnt = ({1'b0, r_idx} + (CNTW+1)'(1)) < {1'b0, r_count};
    assign o_sts.idx_gt_pos  = r_idx > pos_sel;
    assign o_sts.act         = act;

    // single write port per array
    always_comb begin
        we_f  = 1'b0;
        we_l  = 1'b0;
        waddr = r_idx[IW-1:0];
        wd_f  = r_rd_first;
        wd_l  = r_rd_last;
        if (i_ctl.boot || (i_ctl.decide && (r_cmd == bfha_pkg::CMD_INIT))) begin
            we_f  = 1'b1;
            we_l  = 1'b1;
            waddr = '0;
            wd_f  = '0;
            wd_l  = eff - CW'(1);
        end else if (i_ctl.decide && (r_cmd == bfha_pkg::CMD_ALLOC)) begin
            we_f  = alloc_ok && (r_best != r_size);
            waddr = r_pick;
            wd_f  = r_pick_first + r_size;
        end else if (i_ctl.decide && (r_cmd == bfha_pkg::CMD_FREE)) begin
            if (free_ok && join_l) begin
                we_l  = 1'b1;
                waddr = r_left_idx;
                wd_l  = join_r ? r_right_last : r_end;
            end else if (free_ok && join_r) begin
                we_f  = 1'b1;
                waddr = r_pos[IW-1:0];
                wd_f  = r_start;
            end
        end else if (i_ctl.dn_wr || i_ctl.up_wr) begin
            we_f = 1'b1;
            we_l = 1'b1;
        end else if (i_ctl.put) begin
            we_f  = 1'b1;
            we_l  = 1'b1;
            waddr = pos_sel[IW-1:0];
            wd_f  = r_start;
            wd_l  = r_end;
        end
    end

    always_comb begin
        raddr_c = r_idx;
        if (i_ctl.dn_rd)      raddr_c = r_idx + CNTW'(1);
        else if (i_ctl.up_rd) raddr_c = r_idx - CNTW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (we_f) r_mem_first[waddr] <= wd_f;
        if (we_l) r_mem_last[waddr]  <= wd_l;
        r_rd_first <= r_mem_first[raddr_c[IW-1:0]];
        r_rd_last  <= r_mem_last[raddr_c[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= bfha_pkg::MEM_RESET;
            r_count    <= '0;
            r_free     <= '0;
            r_status   <= bfha_pkg::ST_OK;
        end else begin
            if (i_cfg_we) r_mem_size <= i_cfg_wdata;
            if (i_ctl.boot || (i_ctl.decide && (r_cmd == bfha_pkg::CMD_INIT))) begin
                r_count <= (eff == '0) ? CNTW'(0) : CNTW'(1);
                r_free  <= eff[SW-1:0];
            end
            if (i_ctl.load) begin
                r_cmd       <= bfha_pkg::t_cmd'(i_cmd);
                r_start     <= CW'(i_region_start);
                r_size      <= CW'(i_region_size);
                r_end       <= CW'(i_region_start) + CW'(i_region_size) - CW'(1);
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_ovl       <= 1'b0;
                r_left_vld  <= 1'b0;
                r_pos_found <= 1'b0;
                r_status    <= bfha_pkg::ST_OK;
                r_base      <= '0;
                r_laddr     <= '0;
            end
            if (i_ctl.scan_ev) begin
                if ((hs >= r_size) && (!r_found || (hs <= r_best))) begin
                    r_found      <= 1'b1;
                    r_best       <= hs;
                    r_pick       <= r_idx[IW-1:0];
                    r_pick_first <= r_rd_first;
                end
                if ((r_start <= r_rd_last) && (r_rd_first <= r_end)) r_ovl <= 1'b1;
                if (r_rd_first < r_start) begin
                    r_left_vld  <= 1'b1;
                    r_left_idx  <= r_idx[IW-1:0];
                    r_left_last <= r_rd_last;
                end else if (!r_pos_found) begin
                    r_pos_found   <= 1'b1;
                    r_pos         <= r_idx;
                    r_right_first <= r_rd_first;
                    r_right_last  <= r_rd_last;
                end
                r_idx <= r_idx + CNTW'(1);
            end
            if (i_ctl.decide) begin
                case (r_cmd)
                    bfha_pkg::CMD_ALLOC: begin
                        if (!alloc_ok) begin
                            r_status <= bfha_pkg::ST_NOFIT;
                        end else begin
                            r_base  <= r_pick_first;
                            r_laddr <= r_pick_first + r_size - CW'(1);
                            r_free  <= r_free - r_size[SW-1:0];
                            r_idx   <= CNTW'(r_pick);
                        end
                    end
                    bfha_pkg::CMD_FREE: begin
                        if (!free_ok) begin
                            r_status <= bfha_pkg::ST_NOFIT;
                        end else if (!join_l && !join_r && tbl_full) begin
                            r_status <= bfha_pkg::ST_FULL;
                        end else begin
                            r_free <= r_free + r_size[SW-1:0];
                            r_idx  <= (join_l && join_r) ? r_pos : r_count;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_ctl.dn_wr) r_idx <= r_idx + CNTW'(1);
            if (i_ctl.up_wr) r_idx <= r_idx - CNTW'(1);
            if (i_ctl.put) r_count <= r_count + CNTW'(1);
            if (i_ctl.dec_count) r_count <= r_count - CNTW'(1);
        end
    end

    assign o_base_address = r_base[bfha_pkg::PORT_AW-1:0];
    assign o_last_address = r_laddr[bfha_pkg::PORT_AW-1:0];
    assign o_status       = r_status;
    assign o_free_total   = r_free;

endmodule

// File: rtl/core/bfha_ctrl.sv
// Controller FSM: sequences scan, decision and table shifts.
// Depends on bfha_pkg; drives bfha_datapath.
module bfha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bfha_pkg::t_dp_sts i_sts,
    output bfha_pkg::t_dp_ctl o_ctl,
    output logic              o_busy,
    output logic              o_done
);
    typedef enum logic [13:0] {
        S_BOOT   = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_RD     = 14'b00000000000100,
        S_EV     = 14'b00000000001000,
        S_DEC    = 14'b00000000010000,
        S_DN_CHK = 14'b00000000100000,
        S_DN_RD  = 14'b00000001000000,
        S_DN_WR  = 14'b00000010000000,
        S_FIN    = 14'b00000100000000,
        S_UP_CHK = 14'b00001000000000,
        S_UP_RD  = 14'b00010000000000,
        S_UP_WR  = 14'b00100000000000,
        S_PUT    = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_BOOT;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_BOOT: begin
                o_ctl.boot = 1'b1;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = i_sts.scan_req ? S_RD : S_DEC;
                end
            end
            S_RD: begin
                o_ctl.scan_rd = 1'b1;
                n_state       = S_EV;
            end
            S_EV: begin
                o_ctl.scan_ev = 1'b1;
                n_state       = i_sts.next_lt_cnt ? S_RD : S_DEC;
            end
            S_DEC: begin
                o_ctl.decide = 1'b1;
                case (i_sts.act)
                    bfha_pkg::ACT_SHDN: n_state = S_DN_CHK;
                    bfha_pkg::ACT_SHUP: n_state = S_UP_CHK;
                    default:            n_state = S_DONE;
                endcase
            end
            S_DN_CHK: n_state = i_sts.next_lt_cnt ? S_DN_RD : S_FIN;
            S_DN_RD: begin
                o_ctl.dn_rd = 1'b1;
                n_state     = S_DN_WR;
            end
            S_DN_WR: begin
                o_ctl.dn_wr = 1'b1;
                n_state     = S_DN_CHK;
            end
            S_FIN: begin
                o_ctl.dec_count = 1'b1;
                n_state         = S_DONE;
            end
            S_UP_CHK: n_state = i_sts.idx_gt_pos ? S_UP_RD : S_PUT;
            S_UP_RD: begin
                o_ctl.up_rd = 1'b1;
                n_state     = S_UP_WR;
            end
            S_UP_WR: begin
                o_ctl.up_wr = 1'b1;
                n_state     = S_UP_CHK;
            end
            S_PUT: begin
                o_ctl.put = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// File: rtl/core/best_fit_hole_allocator.sv
// Best-fit hole allocator: one request in, one result strobed out on o_done.
// A request scans every table entry (one memory read, one compare), then decides and
// strobes the result; when a hole is removed or inserted, the later entries are moved
// one at a time (check, read, write) before the result. Init, cmd 3 and requests on an
// empty table go straight to the decision. After reset the block is busy while it writes
// the initial hole. The result is shown for one cycle only; the receiver cannot stall it.
// Depends on bfha_pkg, bfha_ctrl and bfha_datapath.
module best_fit_hole_allocator #(
    parameter int MAX_HOLES = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bfha_pkg::SIZE_W-1:0]   i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [bfha_pkg::CMD_W-1:0]    i_cmd,
    input  logic [bfha_pkg::PORT_AW-1:0]  i_region_start,
    input  logic [bfha_pkg::SIZE_W-1:0]   i_region_size,
    output logic                          o_done,
    output logic [bfha_pkg::PORT_AW-1:0]  o_base_address,
    output logic [bfha_pkg::PORT_AW-1:0]  o_last_address,
    output logic [bfha_pkg::STATUS_W-1:0] o_status,
    output logic [bfha_pkg::SIZE_W-1:0]   o_free_total
);
    bfha_pkg::t_dp_ctl ctl;
    bfha_pkg::t_dp_sts sts;

    bfha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bfha_datapath #(
        .MAX_HOLES (MAX_HOLES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (i_cmd),
        .i_region_start (i_region_start),
        .i_region_size  (i_region_size),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_base_address (o_base_address),
        .o_last_address (o_last_address),
        .o_status       (o_status),
        .o_free_total   (o_free_total)
    );

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != bfha_pkg::ST_OK))
            |-> ((o_base_address == '0) && (o_last_address == '0)))
        else $error("failed request returned a nonzero address");

    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

endmodule

// File: dv/bfha_checker.sv
// Scoreboard for the best-fit hole allocator: keeps its own hole table and free count,
// predicts the result of each accepted item and compares the strobed results in order.
// Depends on bfha_pkg.
`timescale 1ns / 1ps
module bfha_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bfha_pkg::SIZE_W-1:0]   i_cfg_wdata,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [bfha_pkg::CMD_W-1:0]    i_cmd,
    input  logic [bfha_pkg::PORT_AW-1:0]  i_region_start,
    input  logic [bfha_pkg::SIZE_W-1:0]   i_region_size,
    input  logic                          i_done,
    input  logic [bfha_pkg::PORT_AW-1:0]  i_base_address,
    input  logic [bfha_pkg::PORT_AW-1:0]  i_last_address,
    input  logic [bfha_pkg::STATUS_W-1:0] i_status,
    input  logic [bfha_pkg::SIZE_W-1:0]   i_free_total,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_n_ok,
    output int                            o_n_nofit,
    output int                            o_n_full
);
    localparam int HOLES = 16;
    localparam logic [32:0] ADDR_SPAN = 33'h1_0000_0000;

    typedef struct packed {
        logic [31:0]       base;
        logic [31:0]       last;
        bfha_pkg::t_status status;
        logic [32:0]       free;
    } t_answer;

    t_answer     answers_due[$];
    logic [32:0] hole_lo[HOLES];
    logic [32:0] hole_hi[HOLES];
    int          holes_used;
    logic [32:0] words_left;
    logic [32:0] mem_words;

    function automatic logic [32:0] usable_words();
        return (mem_words > ADDR_SPAN) ? ADDR_SPAN : mem_words;
    endfunction

    function automatic void rebuild_holes();
        logic [32:0] m;
        m = usable_words();
        foreach (hole_lo[i]) begin
            hole_lo[i] = '0;
            hole_hi[i] = '0;
        end
        if (m == 0) begin
            holes_used = 0;
            words_left = '0;
        end else begin
            hole_hi[0] = m - 1;
            holes_used = 1;
            words_left = m;
        end
    endfunction

    function automatic void drop_hole(int k);
        for (int i = k; i + 1 < holes_used; i++) begin
            hole_lo[i] = hole_lo[i+1];
            hole_hi[i] = hole_hi[i+1];
        end
        holes_used--;
    endfunction

    function automatic bfha_pkg::t_status carve(logic [32:0] size, output logic [33:0] base,
                                                output logic [33:0] last);
        bit          found;
        int          pick;
        logic [33:0] best;
        logic [33:0] hs;
        found = 0;
        pick = 0;
        best = '0;
        base = '0;
        last = '0;
        if (size == 0) return bfha_pkg::ST_NOFIT;
        for (int i = 0; i < holes_used; i++) begin
            hs = {1'b0, hole_hi[i]} - hole_lo[i] + 1;
            // ties go to the later hole
            if (hs >= size && (!found || hs <= best)) begin
                found = 1;
                best = hs;
                pick = i;
            end
        end
        if (!found) return bfha_pkg::ST_NOFIT;
        base = hole_lo[pick];
        last = {1'b0, hole_lo[pick]} + size - 1;
        if (best == size) drop_hole(pick);
        else hole_lo[pick] = hole_lo[pick] + size;
        words_left = words_left - size;
        return bfha_pkg::ST_OK;
    endfunction

    function automatic bfha_pkg::t_status give_back(logic [31:0] first, logic [32:0] size);
        logic [33:0] fin;
        int          pos;
        bit          jl;
        bit          jr;
        if (size == 0) return bfha_pkg::ST_NOFIT;
        fin = {2'b0, first} + size - 1;
        if (fin >= usable_words()) return bfha_pkg::ST_NOFIT;
        for (int i = 0; i < holes_used; i++)
            if (first <= hole_hi[i] && hole_lo[i] <= fin) return bfha_pkg::ST_NOFIT;
        pos = 0;
        while (pos < holes_used && hole_lo[pos] < first) pos++;
        jl = pos > 0 && ({1'b0, hole_hi[pos-1]} + 1 == first);
        jr = pos < holes_used && (fin + 1 == hole_lo[pos]);
        if (jl && jr) begin
            hole_hi[pos-1] = hole_hi[pos];
            drop_hole(pos);
        end else if (jl) begin
            hole_hi[pos-1] = fin[32:0];
        end else if (jr) begin
            hole_lo[pos] = first;
        end else begin
            if (holes_used >= HOLES) return bfha_pkg::ST_FULL;
            for (int i = holes_used; i > pos; i--) begin
                hole_lo[i] = hole_lo[i-1];
                hole_hi[i] = hole_hi[i-1];
            end
            hole_lo[pos] = first;
            hole_hi[pos] = fin[32:0];
            holes_used++;
        end
        words_left = words_left + size;
        return bfha_pkg::ST_OK;
    endfunction

    function automatic t_answer predict_item(bfha_pkg::t_cmd c, logic [31:0] first,
                                             logic [32:0] size);
        t_answer     a;
        logic [33:0] b;
        logic [33:0] l;
        a = '0;
        a.status = bfha_pkg::ST_OK;
        case (c)
            bfha_pkg::CMD_ALLOC: begin
                a.status = carve(size, b, l);
                if (a.status == bfha_pkg::ST_OK) begin
                    a.base = b[31:0];
                    a.last = l[31:0];
                end
            end
            bfha_pkg::CMD_FREE: a.status = give_back(first, size);
            bfha_pkg::CMD_INIT: rebuild_holes();
            default: ;
        endcase
        a.free = words_left;
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            mem_words = bfha_pkg::MEM_RESET;
            rebuild_holes();
            answers_due.delete();
        end else begin
            if (i_start && !i_busy)
                answers_due.insert(answers_due.size(),
                                   predict_item(bfha_pkg::t_cmd'(i_cmd), i_region_start,
                                                i_region_size));
            if (i_done) begin
                got = '{i_base_address, i_last_address, bfha_pkg::t_status'(i_status),
                        i_free_total};
                case (got.status)
                    bfha_pkg::ST_OK:    o_n_ok++;
                    bfha_pkg::ST_NOFIT: o_n_nofit++;
                    bfha_pkg::ST_FULL:  o_n_full++;
                    default: ;
                endcase
                if (answers_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result at %0t", $realtime);
                end else begin
                    want = answers_due.pop_front();
                    if (got != want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"mismatch at %0t: exp base %h last %h st %0d free %h,",
                                      " got base %h last %h st %0d free %h"},
                                     $realtime, want.base, want.last, want.status, want.free,
                                     got.base, got.last, got.status, got.free);
                    end
                end
            end
            // the new size bounds frees at once; the table is rebuilt only at the next init
            if (i_cfg_we) mem_words = i_cfg_wdata;
        end
        o_pending = answers_due.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_n_ok = 0;
        o_n_nofit = 0;
        o_n_full = 0;
        mem_words = bfha_pkg::MEM_RESET;
        rebuild_holes();
    end
endmodule

// File: dv/testbench.sv
// Top of the allocator testbench: clock, reset, directed and random request streams
// with memory size changes; checking is done by bfha_checker. Depends on bfha_pkg.
`timescale 1ns / 1ps
module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [32:0] i_cfg_wdata;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [31:0] i_region_start;
    logic [32:0] i_region_size;
    logic        o_done;
    logic [31:0] o_base_address;
    logic [31:0] o_last_address;
    logic [1:0]  o_status;
    logic [32:0] o_free_total;
    int          errors, pending, n_ok, n_nofit, n_full;
    int          items_sent;
    bit          quiet;
    logic [32:0] cur_mem;

    typedef struct {
        logic [31:0] base;
        logic [32:0] size;
    } t_region;

    bfha_pkg::t_cmd cmds_in_flight[$];
    t_region        taken[$];

    best_fit_hole_allocator u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .start, .busy,
        .i_cmd, .i_region_start, .i_region_size,
        .o_done, .o_base_address, .o_last_address, .o_status, .o_free_total
    );

    bfha_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_start(start), .i_busy(busy),
        .i_cmd, .i_region_start, .i_region_size,
        .i_done(o_done), .i_base_address(o_base_address), .i_last_address(o_last_address),
        .i_status(o_status), .i_free_total(o_free_total),
        .o_errors(errors), .o_pending(pending),
        .o_n_ok(n_ok), .o_n_nofit(n_nofit), .o_n_full(n_full)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // remember granted regions so the random part can hand them back
    always @(posedge i_clk) begin
        bfha_pkg::t_cmd c;
        if (o_done && cmds_in_flight.size() > 0) begin
            c = cmds_in_flight.pop_front();
            if (c == bfha_pkg::CMD_INIT) taken.delete();
            if (c == bfha_pkg::CMD_ALLOC && o_status == bfha_pkg::ST_OK)
                taken.insert(taken.size(),
                             '{o_base_address, {1'b0, o_last_address} - o_base_address + 1});
        end
    end

    task automatic send(bfha_pkg::t_cmd c, logic [31:0] first, logic [32:0] size);
        int g;
        start <= 1'b1;
        i_cmd <= c;
        i_region_start <= first;
        i_region_size <= size;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        cmds_in_flight.insert(cmds_in_flight.size(), c);
        items_sent++;
        g = 0;
        if (!quiet && $urandom_range(0, 3) == 0) g = $urandom_range(1, 17);
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // drain, then reprogram the size and rebuild the table
    task automatic resize(logic [32:0] m);
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mem = m;
        send(bfha_pkg::CMD_INIT, $urandom, 33'd1);
    endtask

    function automatic logic [32:0] span_of(logic [32:0] m);
        return (m > 33'h1_0000_0000) ? 33'h1_0000_0000 : m;
    endfunction

    task automatic random_burst(int n);
        logic [32:0] eff;
        logic [32:0] sz;
        int          k;
        int          r;
        eff = span_of(cur_mem);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if (eff < 24 || $urandom_range(0, 9) == 0) sz = $urandom_range(1, 8);
                else sz = $urandom_range(1, int'(((eff / 12) > 33'd1_000_000_000)
                                                 ? 33'd1_000_000_000 : eff / 12));
                send(bfha_pkg::CMD_ALLOC, $urandom, sz);
            end else if (r < 85 && taken.size() > 0) begin
                k = $urandom_range(0, taken.size() - 1);
                send(bfha_pkg::CMD_FREE, taken[k].base, taken[k].size);
                // sometimes keep it listed so a double free follows
                if ($urandom_range(0, 7) != 0) taken.delete(k);
            end else if (r < 95) begin
                send(bfha_pkg::CMD_FREE, $urandom, {1'($urandom_range(0, 1)), $urandom});
            end else if (r < 98) begin
                send(bfha_pkg::CMD_ALLOC, $urandom, {1'($urandom_range(0, 1)), $urandom});
            end else begin
                send(bfha_pkg::t_cmd'($urandom_range(0, 3)), $urandom,
                     {1'($urandom_range(0, 1)), $urandom});
            end
        end
    endtask

    initial begin
        logic [32:0] sizes[8];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        start = 1'b0;
        i_cmd = bfha_pkg::CMD_NOP;
        i_region_start = '0;
        i_region_size = '0;
        items_sent = 0;
        quiet = 0;
        cur_mem = bfha_pkg::MEM_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset-size table
        send(bfha_pkg::CMD_ALLOC, 32'd0, 33'd0);
        send(bfha_pkg::CMD_ALLOC, 32'd0, 33'd1048577);
        send(bfha_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 33'd16);
        send(bfha_pkg::CMD_ALLOC, 32'd0, 33'd1);
        send(bfha_pkg::CMD_FREE, 32'd4, 33'd0);
        send(bfha_pkg::CMD_FREE, 32'd1048570, 33'd10);
        send(bfha_pkg::CMD_FREE, 32'd100, 33'd4);
        send(bfha_pkg::CMD_FREE, 32'd4, 33'd4);
        send(bfha_pkg::CMD_FREE, 32'd0, 33'd4);
        send(bfha_pkg::CMD_FREE, 32'd8, 33'd9);
        send(bfha_pkg::CMD_NOP, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
        send(bfha_pkg::CMD_INIT, 32'd0, 33'd0);
        // saturated size, whole-memory exact fit, top-address free
        resize(33'h1_FFFF_FFFF);
        send(bfha_pkg::CMD_ALLOC, 32'd0, 33'h1_0000_0000);
        send(bfha_pkg::CMD_FREE, 32'hFFFF_FFFF, 33'd1);
        send(bfha_pkg::CMD_FREE, 32'd0, 33'hFFFF_FFFF);
        resize(33'd0);
        send(bfha_pkg::CMD_ALLOC, 32'd0, 33'd1);
        send(bfha_pkg::CMD_FREE, 32'd0, 33'd1);
        resize(33'd1);
        send(bfha_pkg::CMD_ALLOC, 32'd0, 33'd1);
        send(bfha_pkg::CMD_FREE, 32'd0, 33'd1);
        // fragment into more holes than the table holds
        resize(33'd64);
        for (int i = 0; i < 40; i++) send(bfha_pkg::CMD_ALLOC, 32'd0, 33'd1);
        for (int i = 0; i < 40; i += 2) send(bfha_pkg::CMD_FREE, 32'(i), 33'd1);
        send(bfha_pkg::CMD_ALLOC, 32'd0, 33'd1);

        sizes = '{33'd32, 33'd100, 33'd1000, 33'd4096, 33'd1048576,
                  33'h1_0000_0000, 33'd300, 33'd77};
        for (int p = 0; p < 8; p++) begin
            if (p == 7) quiet = 1;
            resize((p == 6) ? {1'($urandom_range(0, 1)), $urandom} % 33'd5000 + 33'd1
                            : sizes[p]);
            random_burst(40);
        end

        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("%0d requests across 13 memory configurations: %0d ok, %0d rejected, %0d table full",
                 items_sent, n_ok, n_nofit, n_full);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/bfha_pkg.sv
rtl/core/bfha_datapath.sv
rtl/core/bfha_ctrl.sv
rtl/core/best_fit_hole_allocator.sv
dv/bfha_checker.sv
dv/testbench.sv
